@@ src/isdma_pkg.sv @@
package isdma_pkg;

    // Fixed field widths of the ports
    localparam int INPUT_W       = 5;
    localparam int PORT_SAMPLE_W = 16;

    // Default configuration of the scan block
    localparam int SNAPSHOT_COUNT_DEF   = 10;
    localparam int SNAPSHOT_SPACING_DEF = 10;
    localparam int FEEDBACK_WINDOW_DEF  = 100;
    localparam int MEDIAN_LENGTH_DEF    = 11;
    localparam int MEDIAN_WINDOW_DEF    = 36;
    localparam int SAMPLE_BITS_DEF      = 16;

    // Handshake between neighboring sort cells
    typedef struct packed {
        logic take;     // cell shifts right on this insert
        logic valid;    // cell holds a sample of the current block
    } cell_link_t;

    // Control broadcast to every sort cell
    typedef struct packed {
        logic insert;   // new sample enters the chain
        logic clear;    // block done, empty the chain
    } sort_ctrl_t;

endpackage

@@ src/isdma_sort_cell.sv @@
module isdma_sort_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  isdma_pkg::sort_ctrl_t  ctrl,
    input  logic [SAMPLE_BITS-1:0] new_value,
    input  isdma_pkg::cell_link_t  left_link,
    input  logic [SAMPLE_BITS-1:0] left_value,
    output isdma_pkg::cell_link_t  link,
    output logic [SAMPLE_BITS-1:0] value
);

    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   take;

    // The new sample belongs at or before this cell: it is empty, or holds a larger value
    assign take = ctrl.insert && (!valid_reg || (new_value < value_reg));

    // Empty on clear; else shift in from the left neighbor, or capture the new sample at the edge
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (take)
        begin
            if (left_link.take)
            begin
                value_next = left_value;
                valid_next = left_link.valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.take  = take;
    assign link.valid = valid_reg;
    assign value      = value_reg;

endmodule

@@ src/isdma_const_div.sv @@
module isdma_const_div #(
    parameter int NUM_W   = 23,
    parameter int QUO_W   = 16,
    parameter int DIVISOR = 100
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    output logic             busy,
    output logic [QUO_W-1:0] quotient
);

    // Reciprocal scaling: floor(x / DIVISOR) = (x * Recip) >> ShW for any x below 2**NUM_W
    localparam int ShW = NUM_W + $clog2(DIVISOR);
    localparam int RcW = NUM_W + 2;
    localparam int PrW = NUM_W + RcW;
    localparam logic [63:0] RecipFull =
        ((64'd1 << ShW) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [RcW-1:0] Recip = RcW'(RecipFull);

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic             busy_reg;
    logic             busy_next;
    logic [PrW-1:0]   product;

    // Constant multiply on the registered dividend
    assign product = PrW'(num_reg) * PrW'(Recip);

    // Capture the dividend on start, then form the quotient from it while busy
    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        busy_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = product[ShW +: QUO_W];
        end
    end

    // Quotient is reset so the held mean reads zero before the first window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            quo_reg  <= quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ src/input_scan_debounce_median_average_unit.sv @@
// Input scan unit: one input word is one scan tick carrying five digital
// inputs and a feedback and a pressure converter sample; each tick returns
// one output word with the debounced inputs, the held feedback mean and the
// held pressure median-mean, plus strobes for this tick's changes. Each
// accepted tick passes through the sequencer states in order: ST_IDLE accepts
// the tick and inserts the pressure sample into the sorting cell chain,
// ST_EVAL evaluates the snapshots and the block median, and ST_DIV loads the
// output register. The means come from registered constant-divisor reciprocal
// multipliers; the feedback mean is done within ST_EVAL, while the pressure
// mean is started in ST_EVAL and holds ST_DIV until its quotient is
// registered. Beyond that, the output word waits only while the previous
// word is unread. A new tick is accepted while the previous output word
// still waits.
module input_scan_debounce_median_average_unit #(
    parameter int SNAPSHOT_COUNT   = isdma_pkg::SNAPSHOT_COUNT_DEF,
    parameter int SNAPSHOT_SPACING = isdma_pkg::SNAPSHOT_SPACING_DEF,
    parameter int FEEDBACK_WINDOW  = isdma_pkg::FEEDBACK_WINDOW_DEF,
    parameter int MEDIAN_LENGTH    = isdma_pkg::MEDIAN_LENGTH_DEF,
    parameter int MEDIAN_WINDOW    = isdma_pkg::MEDIAN_WINDOW_DEF,
    parameter int SAMPLE_BITS      = isdma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [isdma_pkg::INPUT_W-1:0]       inputs_active,
    input  logic [isdma_pkg::PORT_SAMPLE_W-1:0] feedback_sample,
    input  logic [isdma_pkg::PORT_SAMPLE_W-1:0] pressure_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [isdma_pkg::INPUT_W-1:0]       debounced_inputs,
    output logic                                inputs_changed,
    output logic [isdma_pkg::PORT_SAMPLE_W-1:0] feedback_mean,
    output logic                                feedback_valid,
    output logic [isdma_pkg::PORT_SAMPLE_W-1:0] pressure_mean,
    output logic                                pressure_valid
);

    import isdma_pkg::*;

    localparam int SpW  = (SNAPSHOT_SPACING > 1) ? $clog2(SNAPSHOT_SPACING) : 1;
    localparam int SlW  = $clog2(SNAPSHOT_COUNT);
    localparam int FcW  = (FEEDBACK_WINDOW > 1) ? $clog2(FEEDBACK_WINDOW) : 1;
    localparam int FsW  = SAMPLE_BITS + $clog2(FEEDBACK_WINDOW);
    localparam int PiW  = $clog2(MEDIAN_LENGTH);
    localparam int McW  = (MEDIAN_WINDOW > 1) ? $clog2(MEDIAN_WINDOW) : 1;
    localparam int MsW  = SAMPLE_BITS + $clog2(MEDIAN_WINDOW);
    localparam int Mid  = MEDIAN_LENGTH / 2;

    // Sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;

    // Debounce state
    logic [SpW-1:0]         spc_reg;
    logic [SpW-1:0]         spc_next;
    logic [SlW-1:0]         slot_reg;
    logic [SlW-1:0]         slot_next;
    logic [INPUT_W-1:0]     snap_reg [SNAPSHOT_COUNT];
    logic [INPUT_W-1:0]     snap_next [SNAPSHOT_COUNT];
    logic [INPUT_W-1:0]     acc_reg;
    logic [INPUT_W-1:0]     acc_next;
    logic                   period_end_reg;
    logic                   period_end_next;
    logic                   changed_reg;
    logic                   changed_next;
    logic                   agree;

    // Feedback averaging
    logic [FsW-1:0]         fb_sum_reg;
    logic [FsW-1:0]         fb_sum_next;
    logic [FsW-1:0]         fb_total;
    logic [FcW-1:0]         fb_cnt_reg;
    logic [FcW-1:0]         fb_cnt_next;
    logic                   fb_flag_reg;
    logic                   fb_flag_next;
    logic                   fb_start;
    logic                   fb_busy;
    logic [SAMPLE_BITS-1:0] fb_quo;

    // Pressure median chain and averaging
    logic [PiW-1:0]         pidx_reg;
    logic [PiW-1:0]         pidx_next;
    logic                   median_due_reg;
    logic                   median_due_next;
    logic [MsW-1:0]         med_sum_reg;
    logic [MsW-1:0]         med_sum_next;
    logic [MsW-1:0]         med_total;
    logic [McW-1:0]         med_cnt_reg;
    logic [McW-1:0]         med_cnt_next;
    logic                   pr_flag_reg;
    logic                   pr_flag_next;
    logic                   pr_start;
    logic                   pr_busy;
    logic [SAMPLE_BITS-1:0] pr_quo;
    sort_ctrl_t             sort_ctrl;
    cell_link_t             cell_link  [MEDIAN_LENGTH];
    logic [SAMPLE_BITS-1:0] cell_value [MEDIAN_LENGTH];
    logic [MEDIAN_LENGTH-1:0] cell_valid;

    // Output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [INPUT_W-1:0]     dbn_out_reg;
    logic                   chg_out_reg;
    logic [SAMPLE_BITS-1:0] fbm_out_reg;
    logic                   fbv_out_reg;
    logic [SAMPLE_BITS-1:0] prm_out_reg;
    logic                   prv_out_reg;
    logic                   out_load;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] fb_in;
    logic [SAMPLE_BITS-1:0] pr_in;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign fb_in    = feedback_sample[SAMPLE_BITS-1:0];
    assign pr_in    = pressure_sample[SAMPLE_BITS-1:0];
    assign out_load = (state_reg == ST_DIV) && !fb_busy && !pr_busy
                      && (!out_valid_reg || out_ready);

    assign fb_total  = fb_sum_reg + FsW'(fb_in);
    assign med_total = med_sum_reg + MsW'(cell_value[Mid]);

    // All snapshots agree with the first one
    always_comb
    begin
        agree = 1'b1;
        for (int i = 1; i < SNAPSHOT_COUNT; i++)
        begin
            if (snap_reg[i] != snap_reg[0])
            begin
                agree = 1'b0;
            end
        end
    end

    // Sequencer and accumulator updates
    always_comb
    begin
        state_next      = state_reg;
        spc_next        = spc_reg;
        slot_next       = slot_reg;
        snap_next       = snap_reg;
        acc_next        = acc_reg;
        period_end_next = period_end_reg;
        changed_next    = changed_reg;
        fb_sum_next     = fb_sum_reg;
        fb_cnt_next     = fb_cnt_reg;
        fb_flag_next    = fb_flag_reg;
        fb_start        = 1'b0;
        pidx_next       = pidx_reg;
        median_due_next = median_due_reg;
        med_sum_next    = med_sum_reg;
        med_cnt_next    = med_cnt_reg;
        pr_flag_next    = pr_flag_reg;
        pr_start        = 1'b0;
        sort_ctrl       = '0;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // snapshot on the first tick of each spacing interval
                    if (spc_reg == '0)
                    begin
                        snap_next[0] = inputs_active;
                        for (int i = 1; i < SNAPSHOT_COUNT; i++)
                        begin
                            snap_next[i] = snap_reg[i-1];
                        end
                    end
                    period_end_next = 1'b0;
                    if (spc_reg == SpW'(SNAPSHOT_SPACING - 1))
                    begin
                        spc_next = '0;
                        if (slot_reg == SlW'(SNAPSHOT_COUNT - 1))
                        begin
                            slot_next       = '0;
                            period_end_next = 1'b1;
                        end
                        else
                        begin
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        spc_next = spc_reg + 1'b1;
                    end
                    changed_next = 1'b0;

                    // feedback window
                    fb_flag_next = 1'b0;
                    if (fb_cnt_reg == FcW'(FEEDBACK_WINDOW - 1))
                    begin
                        fb_start     = 1'b1;
                        fb_flag_next = 1'b1;
                        fb_sum_next  = '0;
                        fb_cnt_next  = '0;
                    end
                    else
                    begin
                        fb_sum_next = fb_total;
                        fb_cnt_next = fb_cnt_reg + 1'b1;
                    end

                    // pressure sample into the sorting chain
                    sort_ctrl.insert = 1'b1;
                    pr_flag_next     = 1'b0;
                    if (pidx_reg == PiW'(MEDIAN_LENGTH - 1))
                    begin
                        pidx_next       = '0;
                        median_due_next = 1'b1;
                    end
                    else
                    begin
                        pidx_next       = pidx_reg + 1'b1;
                        median_due_next = 1'b0;
                    end
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (period_end_reg && agree)
                begin
                    changed_next = (snap_reg[0] != acc_reg);
                    acc_next     = snap_reg[0];
                end
                if (median_due_reg)
                begin
                    sort_ctrl.clear = 1'b1;
                    if (med_cnt_reg == McW'(MEDIAN_WINDOW - 1))
                    begin
                        pr_start     = 1'b1;
                        pr_flag_next = 1'b1;
                        med_sum_next = '0;
                        med_cnt_next = '0;
                    end
                    else
                    begin
                        med_sum_next = med_total;
                        med_cnt_next = med_cnt_reg + 1'b1;
                    end
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            spc_reg        <= '0;
            slot_reg       <= '0;
            acc_reg        <= '0;
            period_end_reg <= 1'b0;
            changed_reg    <= 1'b0;
            fb_sum_reg     <= '0;
            fb_cnt_reg     <= '0;
            fb_flag_reg    <= 1'b0;
            pidx_reg       <= '0;
            median_due_reg <= 1'b0;
            med_sum_reg    <= '0;
            med_cnt_reg    <= '0;
            pr_flag_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            spc_reg        <= spc_next;
            slot_reg       <= slot_next;
            acc_reg        <= acc_next;
            period_end_reg <= period_end_next;
            changed_reg    <= changed_next;
            fb_sum_reg     <= fb_sum_next;
            fb_cnt_reg     <= fb_cnt_next;
            fb_flag_reg    <= fb_flag_next;
            pidx_reg       <= pidx_next;
            median_due_reg <= median_due_next;
            med_sum_reg    <= med_sum_next;
            med_cnt_reg    <= med_cnt_next;
            pr_flag_reg    <= pr_flag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Snapshot chain and output word
    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
        if (out_load)
        begin
            dbn_out_reg <= acc_reg;
            chg_out_reg <= changed_reg;
            fbm_out_reg <= fb_quo;
            fbv_out_reg <= fb_flag_reg;
            prm_out_reg <= pr_quo;
            prv_out_reg <= pr_flag_reg;
        end
    end

    // Insertion sort chain: cell 0 holds the smallest sample of the block
    for (genvar g = 0; g < MEDIAN_LENGTH; g++)
    begin : g_cell
        cell_link_t             left_link;
        logic [SAMPLE_BITS-1:0] left_value;
        if (g == 0)
        begin : g_first
            assign left_link  = '0;
            assign left_value = '0;
        end
        else
        begin : g_rest
            assign left_link  = cell_link[g-1];
            assign left_value = cell_value[g-1];
        end
        isdma_sort_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (sort_ctrl),
            .new_value  (pr_in),
            .left_link  (left_link),
            .left_value (left_value),
            .link       (cell_link[g]),
            .value      (cell_value[g])
        );
        assign cell_valid[g] = cell_link[g].valid;
    end

    // Window means
    isdma_const_div #(
        .NUM_W   (FsW),
        .QUO_W   (SAMPLE_BITS),
        .DIVISOR (FEEDBACK_WINDOW)
    ) u_fb_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fb_start),
        .dividend (fb_total),
        .busy     (fb_busy),
        .quotient (fb_quo)
    );

    isdma_const_div #(
        .NUM_W   (MsW),
        .QUO_W   (SAMPLE_BITS),
        .DIVISOR (MEDIAN_WINDOW)
    ) u_pr_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pr_start),
        .dividend (med_total),
        .busy     (pr_busy),
        .quotient (pr_quo)
    );

    assign out_valid        = out_valid_reg;
    assign debounced_inputs = dbn_out_reg;
    assign inputs_changed   = chg_out_reg;
    assign feedback_mean    = PORT_SAMPLE_W'(fbm_out_reg);
    assign feedback_valid   = fbv_out_reg;
    assign pressure_mean    = PORT_SAMPLE_W'(prm_out_reg);
    assign pressure_valid   = prv_out_reg;

    // Sort chain fill level tracks the block index between ticks
    a_chain_fill : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(cell_valid) == int'(pidx_reg)))
        else $error("sort chain fill does not match block index");

    // Dividers are idle whenever a new tick can enter
    a_div_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!fb_busy && !pr_busy))
        else $error("divider busy while ready for a new tick");

    // A change strobe only comes with a snapshot period end
    a_change_period : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && changed_reg |-> period_end_reg)
        else $error("input change flagged outside a snapshot period end");

endmodule
